[hdl/oqv_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// oqv_pkg
// Types and codes shared by the oriented quad vertex generator files.
// ----------------------------------------------------------------------------
package oqv_pkg;

   // orientation modes, all eight codes are legal
   typedef enum logic [2:0] {
      MODE_NONE       = 3'd0,
      MODE_FLIPX      = 3'd1,
      MODE_FLIPY      = 3'd2,
      MODE_ROT90      = 3'd3,
      MODE_ROT90FLIPY = 3'd4,
      MODE_ROT180     = 3'd5,
      MODE_ROT270     = 3'd6,
      MODE_ROT270FLIPY = 3'd7
   } orient_mode_type;

   // configuration register indexes
   localparam logic [1:0] CSR_ORIENTATION_MODE = 2'd0;
   localparam logic [1:0] CSR_TARGET_WIDTH     = 2'd1;
   localparam logic [1:0] CSR_TARGET_HEIGHT    = 2'd2;

   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 16;

   localparam logic [1:0] CORNER_LAST = 2'd3;

   typedef struct packed {
      logic signed [23:0] rect_left;
      logic signed [23:0] rect_top;
      logic        [22:0] rect_width;
      logic        [22:0] rect_height;
      logic        [16:0] tex_left;
      logic        [16:0] tex_top;
      logic        [16:0] tex_right;
      logic        [16:0] tex_bottom;
      logic signed [23:0] offset_x;
      logic signed [23:0] offset_y;
   } quad_type;

   typedef struct packed {
      logic        [1:0]  corner_index;
      logic signed [23:0] vertex_x;
      logic signed [23:0] vertex_y;
      logic        [16:0] vertex_u;
      logic        [16:0] vertex_v;
      logic               last_corner;
   } vertex_type;

endpackage

[hdl/oqv_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// oqv_req_if / oqv_rsp_if
// Valid/ready channels carrying one quad request and one vertex result.
// ----------------------------------------------------------------------------
interface oqv_req_if;
   logic              valid;
   logic              ready;
   oqv_pkg::quad_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

interface oqv_rsp_if;
   logic                valid;
   logic                ready;
   oqv_pkg::vertex_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

[hdl/oriented_quad_vertex_gen.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// oriented_quad_vertex_gen
// Expands a screen rectangle into the four corner vertices of a quad under
// one of eight orientation modes, with saturated Q16.8 positions.
// ----------------------------------------------------------------------------
//
//  channel | dir | handshake          | payload
//  --------+-----+--------------------+-------------------------------------
//  req     | in  | valid/ready        | quad: rect, texture rect, offset
//  rsp     | out | valid/ready        | vertex: corner, x, y, u, v, last
//  csr     | in  | write enable only  | index, 16-bit data, no read-back
//
//  One quad gives four vertex transfers, corners a, b, c, d in order, over
//  the single result port. A quad passes the input register and then the
//  result register before its first vertex appears. A new quad is taken
//  in the same cycle the last corner of the previous one moves into the
//  result register. Reset is synchronous and clears the control state and
//  sets the configuration registers (mode none, target 1 x 1). A stall on
//  rsp holds both stages.
//
module oriented_quad_vertex_gen #(
   parameter int COORD_FRAC_BITS = 8
) (
   input  logic                                  clock,
   input  logic                                  reset,
   oqv_req_if.sink                               req_chan,
   oqv_rsp_if.source                             rsp_chan,
   input  logic                                  csr_wen,
   input  logic [oqv_pkg::CSR_INDEX_W-1:0]       csr_index,
   input  logic [oqv_pkg::CSR_DATA_W-1:0]        csr_wdata
);

   // target size in Q(16).F, and the exact sum width before saturation
   localparam int TW_W  = 16 + COORD_FRAC_BITS;
   localparam int SUM_W = ((TW_W > 25) ? TW_W : 25) + 2;

   localparam logic signed [SUM_W-1:0] SAT_HI = $signed({{(SUM_W-24){1'b0}}, 24'h7FFFFF});
   localparam logic signed [SUM_W-1:0] SAT_LO = $signed({{(SUM_W-24){1'b1}}, 24'h800000});

   // ------------------------------------------------------------------
   // configuration registers
   // ------------------------------------------------------------------
   oqv_pkg::orient_mode_type mode_ff;
   logic [15:0]              target_width_ff;
   logic [15:0]              target_height_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff          <= oqv_pkg::MODE_NONE;
         target_width_ff  <= 16'd1;
         target_height_ff <= 16'd1;
      end else if (csr_wen) begin
         unique case (csr_index)
            oqv_pkg::CSR_ORIENTATION_MODE: begin
               mode_ff <= oqv_pkg::orient_mode_type'(csr_wdata[2:0]);
            end
            oqv_pkg::CSR_TARGET_WIDTH: begin
               target_width_ff <= csr_wdata;
            end
            oqv_pkg::CSR_TARGET_HEIGHT: begin
               target_height_ff <= csr_wdata;
            end
            default: begin
               // unmapped index: write dropped
            end
         endcase
      end
   end

   // which axes get mirrored against the target size
   logic mir_x;
   logic mir_y;

   always_comb begin
      mir_x = 1'b0;
      mir_y = 1'b0;
      case (mode_ff) inside
         oqv_pkg::MODE_FLIPX, oqv_pkg::MODE_ROT90: begin
            mir_x = 1'b1;
         end
         oqv_pkg::MODE_FLIPY, oqv_pkg::MODE_ROT270: begin
            mir_y = 1'b1;
         end
         oqv_pkg::MODE_ROT90FLIPY, oqv_pkg::MODE_ROT180: begin
            mir_x = 1'b1;
            mir_y = 1'b1;
         end
         default: begin
            mir_x = 1'b0;
            mir_y = 1'b0;
         end
      endcase
   end

   // ------------------------------------------------------------------
   // input stage: rectangle edges, texture rect and adjusted offsets
   // ------------------------------------------------------------------
   logic                  in_valid_ff;
   logic [1:0]            corner_ff;
   logic signed [24:0]    left_ff,  left_in;
   logic signed [24:0]    top_ff,   top_in;
   logic signed [24:0]    right_ff, right_in;
   logic signed [24:0]    bot_ff,   bot_in;
   logic [16:0]           tl_ff, tt_ff, tr_ff, tb_ff;
   logic signed [24:0]    offx_ff, offx_in;
   logic signed [24:0]    offy_ff, offy_in;

   logic signed [24:0]    pix_x;
   logic signed [24:0]    pix_y;

   logic                  out_valid_ff;
   logic                  out_load;
   logic                  in_done;
   logic                  req_xfer;

   assign out_load = in_valid_ff && (!out_valid_ff || rsp_chan.ready);
   assign in_done  = out_load && (corner_ff == oqv_pkg::CORNER_LAST);
   assign req_chan.ready = !in_valid_ff || in_done;
   assign req_xfer = req_chan.valid && req_chan.ready;

   // one whole pixel added on a mirrored axis of odd target size
   assign pix_x = $signed({24'd0, target_width_ff[0]}  << COORD_FRAC_BITS);
   assign pix_y = $signed({24'd0, target_height_ff[0]} << COORD_FRAC_BITS);

   always_comb begin
      left_in  = {req_chan.payload.rect_left[23], req_chan.payload.rect_left};
      top_in   = {req_chan.payload.rect_top[23],  req_chan.payload.rect_top};
      right_in = left_in + $signed({2'b00, req_chan.payload.rect_width});
      bot_in   = top_in  + $signed({2'b00, req_chan.payload.rect_height});
      offx_in  = {req_chan.payload.offset_x[23], req_chan.payload.offset_x}
                 + (mir_x ? pix_x : 25'sd0);
      offy_in  = {req_chan.payload.offset_y[23], req_chan.payload.offset_y}
                 + (mir_y ? pix_y : 25'sd0);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
         corner_ff   <= 2'd0;
      end else begin
         if (req_xfer) begin
            in_valid_ff <= 1'b1;
         end else if (in_done) begin
            in_valid_ff <= 1'b0;
         end
         if (out_load) begin
            corner_ff <= corner_ff + 2'd1;   // wraps to corner a after d
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_xfer) begin
         left_ff  <= left_in;
         top_ff   <= top_in;
         right_ff <= right_in;
         bot_ff   <= bot_in;
         tl_ff    <= req_chan.payload.tex_left;
         tt_ff    <= req_chan.payload.tex_top;
         tr_ff    <= req_chan.payload.tex_right;
         tb_ff    <= req_chan.payload.tex_bottom;
         offx_ff  <= offx_in;
         offy_ff  <= offy_in;
      end
   end

   // ------------------------------------------------------------------
   // corner select: bit 0 of the corner walks the first edge pair,
   // bit 1 the second; rotations swap which rectangle axis feeds x
   // ------------------------------------------------------------------
   logic               k0, k1;
   logic signed [24:0] base_x, base_y;
   logic               u_right, v_bottom;

   assign k0 = corner_ff[0];
   assign k1 = corner_ff[1];

   always_comb begin
      unique case (mode_ff)
         oqv_pkg::MODE_NONE: begin
            base_x = k0 ? right_ff : left_ff;  base_y = k1 ? bot_ff : top_ff;
            u_right = k0;  v_bottom = k1;
         end
         oqv_pkg::MODE_FLIPX: begin
            base_x = k0 ? left_ff : right_ff;  base_y = k1 ? bot_ff : top_ff;
            u_right = !k0; v_bottom = k1;
         end
         oqv_pkg::MODE_FLIPY: begin
            base_x = k0 ? right_ff : left_ff;  base_y = k1 ? top_ff : bot_ff;
            u_right = k0;  v_bottom = !k1;
         end
         oqv_pkg::MODE_ROT90: begin
            base_x = k0 ? top_ff : bot_ff;     base_y = k1 ? right_ff : left_ff;
            u_right = k1;  v_bottom = !k0;
         end
         oqv_pkg::MODE_ROT90FLIPY: begin
            base_x = k0 ? top_ff : bot_ff;     base_y = k1 ? left_ff : right_ff;
            u_right = !k1; v_bottom = !k0;
         end
         oqv_pkg::MODE_ROT180: begin
            base_x = k0 ? left_ff : right_ff;  base_y = k1 ? top_ff : bot_ff;
            u_right = !k0; v_bottom = !k1;
         end
         oqv_pkg::MODE_ROT270: begin
            base_x = k0 ? bot_ff : top_ff;     base_y = k1 ? left_ff : right_ff;
            u_right = !k1; v_bottom = k0;
         end
         default: begin   // rotate 270 with Y flip
            base_x = k0 ? bot_ff : top_ff;     base_y = k1 ? right_ff : left_ff;
            u_right = k1;  v_bottom = k0;
         end
      endcase
   end

   // ------------------------------------------------------------------
   // position math at full width, saturated once to signed Q16.8
   // ------------------------------------------------------------------
   logic [SUM_W-1:0]        tw_full, th_full;
   logic signed [SUM_W-1:0] bx_ext, by_ext, ox_ext, oy_ext;
   logic signed [SUM_W-1:0] pos_x, pos_y;

   function automatic logic signed [23:0] sat_pos(input logic signed [SUM_W-1:0] v);
      logic signed [23:0] r;
      if (v > SAT_HI) begin
         r = 24'sh7FFFFF;
      end else if (v < SAT_LO) begin
         r = -24'sh800000;
      end else begin
         r = v[23:0];
      end
      return r;
   endfunction

   assign tw_full = {{(SUM_W-16){1'b0}}, target_width_ff}  << COORD_FRAC_BITS;
   assign th_full = {{(SUM_W-16){1'b0}}, target_height_ff} << COORD_FRAC_BITS;
   assign bx_ext  = {{(SUM_W-25){base_x[24]}},  base_x};
   assign by_ext  = {{(SUM_W-25){base_y[24]}},  base_y};
   assign ox_ext  = {{(SUM_W-25){offx_ff[24]}}, offx_ff};
   assign oy_ext  = {{(SUM_W-25){offy_ff[24]}}, offy_ff};

   assign pos_x = (mir_x ? ($signed(tw_full) - bx_ext) : bx_ext) + ox_ext;
   assign pos_y = (mir_y ? ($signed(th_full) - by_ext) : by_ext) + oy_ext;

   // ------------------------------------------------------------------
   // result register
   // ------------------------------------------------------------------
   oqv_pkg::vertex_type rsp_payload_ff, rsp_payload_in;

   always_comb begin
      rsp_payload_in.corner_index = corner_ff;
      rsp_payload_in.vertex_x     = sat_pos(pos_x);
      rsp_payload_in.vertex_y     = sat_pos(pos_y);
      rsp_payload_in.vertex_u     = u_right  ? tr_ff : tl_ff;
      rsp_payload_in.vertex_v     = v_bottom ? tb_ff : tt_ff;
      rsp_payload_in.last_corner  = (corner_ff == oqv_pkg::CORNER_LAST);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (out_load) begin
         out_valid_ff <= 1'b1;
      end else if (rsp_chan.ready) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (out_load) begin
         rsp_payload_ff <= rsp_payload_in;
      end
   end

   assign rsp_chan.valid   = out_valid_ff;
   assign rsp_chan.payload = rsp_payload_ff;

endmodule

[hdl/oqv_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// oqv_checker
// Port-level checks for the oriented quad vertex generator.
// ----------------------------------------------------------------------------
module oqv_checker (
   input logic                clock,
   input logic                reset,
   input logic                req_valid,
   input logic                req_ready,
   input logic                rsp_valid,
   input logic                rsp_ready,
   input oqv_pkg::vertex_type rsp_payload
);

   // nothing comes out right after reset
   a_reset_quiet: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("rsp valid after reset");

   // corners of a quad leave back to back, in order
   a_corner_seq: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_ready && !rsp_payload.last_corner) |=>
         (rsp_valid &&
          rsp_payload.corner_index == 2'($past(rsp_payload.corner_index) + 2'd1)))
      else $error("corner sequence broken");

   // an accepted quad is followed by a valid vertex on rsp
   a_req_to_rsp: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |-> ##2 rsp_valid)
      else $error("no vertex after quad transfer");

   // a stalled vertex holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(rsp_payload)))
      else $error("stalled vertex changed");

endmodule

bind oriented_quad_vertex_gen oqv_checker u_oqv_checker (
   .clock       (clock),
   .reset       (reset),
   .req_valid   (req_chan.valid),
   .req_ready   (req_chan.ready),
   .rsp_valid   (rsp_chan.valid),
   .rsp_ready   (rsp_chan.ready),
   .rsp_payload (rsp_chan.payload)
);
